// ===== src/pcg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types and constants of the peak compressor gain stage.
// ----------------------------------------------------------------------------
package pcg_pkg;

	typedef struct packed {
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic signed [15:0] sample_c;
		logic signed [15:0] sample_d;
	} frame_t;

	typedef struct packed {
		logic signed [15:0] out_a;
		logic signed [15:0] out_b;
		logic signed [15:0] out_c;
		logic signed [15:0] out_d;
		logic [15:0]        applied_gain;
	} result_t;

	localparam int unsigned IO_CHANNELS = 4;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_THRESHOLD = 3'd0;
	localparam logic [2:0] REG_SLOPE     = 3'd1;
	localparam logic [2:0] REG_ATTACK    = 3'd2;
	localparam logic [2:0] REG_RELEASE   = 3'd3;
	localparam logic [2:0] REG_CHANNELS  = 3'd4;

	localparam logic [15:0] RST_THRESHOLD = 16'd16384;
	localparam logic [15:0] RST_SLOPE     = 16'd32768;
	localparam logic [15:0] RST_ATTACK    = 16'd65000;
	localparam logic [15:0] RST_RELEASE   = 16'd65500;
	localparam logic [2:0]  RST_CHANNELS  = 3'd2;

	localparam logic [15:0] GAIN_ONE   = 16'd32768;
	localparam logic [15:0] FULL_SCALE = 16'd32768;
	localparam logic [15:0] EXP_C1     = 16'd43024;
	localparam logic [15:0] EXP_C2     = 16'd22512;

	// Shared multiplier: 20 by 20 bits, four multiplier bits per cycle.
	localparam int unsigned MUL_W     = 20;
	localparam int unsigned MUL_DIGIT = 4;
	localparam logic [2:0]  MUL_LAST  = 3'd4;

endpackage

// ===== src/peak_compressor_gain.sv =====
// ----------------------------------------------------------------------------
// peak_compressor_gain
// Feed-forward peak compressor: envelope follower, log-domain gain, scaling.
// ----------------------------------------------------------------------------
// One frame is handled at a time. Every product goes through one shared
// shift-add multiplier that takes four multiplier bits per cycle. A frame
// whose envelope ends at or below the threshold skips the logarithms and is
// scaled by unity gain; a frame that is compressed spends most of its time
// in the two base-2 logarithms, each of which is sixteen dependent squarings
// on that multiplier. A finished frame waits in the output register while
// the next frame is accepted.
// Configuration writes are always ready.
module peak_compressor_gain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	input  pcg_pkg::frame_t   frame,
	output logic              result_valid,
	input  logic              result_stall,
	output pcg_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [15:0]       cfg_data
);
	import pcg_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ENV      = 4'd1;
	localparam logic [3:0] ST_ENV_W    = 4'd2;
	localparam logic [3:0] ST_LOG_NORM = 4'd3;
	localparam logic [3:0] ST_LOG_SQ   = 4'd4;
	localparam logic [3:0] ST_LOG_W    = 4'd5;
	localparam logic [3:0] ST_SLOPE    = 4'd6;
	localparam logic [3:0] ST_SLOPE_W  = 4'd7;
	localparam logic [3:0] ST_EXP1     = 4'd8;
	localparam logic [3:0] ST_EXP1_W   = 4'd9;
	localparam logic [3:0] ST_EXP2     = 4'd10;
	localparam logic [3:0] ST_EXP2_W   = 4'd11;
	localparam logic [3:0] ST_OUT      = 4'd12;
	localparam logic [3:0] ST_OUT_W    = 4'd13;
	localparam logic [3:0] ST_DONE     = 4'd14;

	function automatic logic [15:0] mag16(logic signed [15:0] s);
		logic [16:0] w;
		w = s[15] ? (17'd0 - {1'b1, s}) : {1'b0, s};
		return w[15:0];
	endfunction

	function automatic logic [3:0] msb16(logic [15:0] x);
		logic [3:0] m;
		m = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (x[i]) m = 4'(i);
		end
		return m;
	endfunction

	// Configuration registers.
	logic [15:0] thr_q, slope_q, atk_q, rel_q;
	logic [2:0]  chan_q;

	// Sequencer and datapath registers.
	logic [3:0]              state_q;
	frame_t                  frame_q;
	logic [2:0]              count_q;
	logic [15:0]             peak_q, env_q, target_q;
	logic                    dn_q;
	logic                    log_sel_q;
	logic [3:0]              msb_q, iter_q, k_q;
	logic [15:0]             n_q, frac_q, gain_q, c_q;
	logic [19:0]             log_e_q, diff_q;
	logic [16:0]             x_q;
	logic [1:0]              ch_q;
	logic [3:0][15:0]        res_q;
	logic                    result_valid_q;
	result_t                 result_q;

	// Shared multiplier.
	logic [MUL_W-1:0]        mul_a_q, mul_b_q;
	logic [2*MUL_W-1:0]      mul_acc_q;
	logic [2:0]              mul_cnt_q;
	logic                    mul_busy_q;
	logic                    mul_go;
	logic [MUL_W-1:0]        mul_go_a, mul_go_b;

	// Combinational helpers.
	logic [15:0] thr_eff;
	logic [2:0]  count_in;
	logic [15:0] mag_in [IO_CHANNELS];
	logic [15:0] peak_in;
	logic [15:0] target_c, coeff_c, d_c, step_c, env_new;
	logic [15:0] log_x;
	logic [3:0]  log_msb;
	logic [16:0] sq;
	logic [15:0] frac_nx, n_nx;
	logic [19:0] logv, slope_l;
	logic [17:0] p_c, g_c;
	logic signed [15:0] s_ch;
	logic        ch_act;
	logic [31:0] prod_p, prod_s;
	logic        out_load;

	assign thr_eff = (thr_q == 16'd0) ? 16'd1 : thr_q;

	always_comb begin
		if (chan_q == 3'd0)
			count_in = 3'd1;
		else if (chan_q > 3'(IO_CHANNELS))
			count_in = 3'(IO_CHANNELS);
		else
			count_in = chan_q;
		mag_in[0] = mag16(frame.sample_a);
		mag_in[1] = mag16(frame.sample_b);
		mag_in[2] = mag16(frame.sample_c);
		mag_in[3] = mag16(frame.sample_d);
		peak_in = 16'd0;
		for (int i = 0; i < IO_CHANNELS; i++) begin
			if (3'(i) < count_in && mag_in[i] > peak_in) peak_in = mag_in[i];
		end
	end

	always_comb begin
		target_c = (peak_q > thr_eff) ? peak_q : env_q;
		coeff_c  = (peak_q > env_q) ? atk_q : rel_q;
		d_c      = (env_q >= target_c) ? (env_q - target_c) : (target_c - env_q);
		step_c   = mul_acc_q[31:16];
		env_new  = dn_q ? (target_q + step_c) : (target_q - step_c);
	end

	// Logarithm: normalize, then one squaring per fraction bit.
	assign log_x   = log_sel_q ? thr_eff : env_q;
	assign log_msb = msb16(log_x);
	assign sq      = mul_acc_q[31:15];
	assign frac_nx = {frac_q[14:0], sq[16]};
	assign n_nx    = sq[16] ? sq[16:1] : sq[15:0];
	assign logv    = {msb_q, frac_nx};
	assign slope_l = mul_acc_q[35:16];

	assign p_c = 18'd65536 + {1'b0, mul_acc_q[32:16]};
	assign g_c = p_c >> ({1'b0, k_q} + 5'd2);

	always_comb begin
		case (ch_q)
			2'd0:    s_ch = frame_q.sample_a;
			2'd1:    s_ch = frame_q.sample_b;
			2'd2:    s_ch = frame_q.sample_c;
			default: s_ch = frame_q.sample_d;
		endcase
	end
	assign ch_act = ({1'b0, ch_q} < count_q);
	assign prod_p = mul_acc_q[31:0];
	// Negating before the arithmetic shift rounds toward minus infinity.
	assign prod_s = s_ch[15] ? (32'd0 - prod_p) : prod_p;

	always_comb begin
		mul_go   = 1'b0;
		mul_go_a = '0;
		mul_go_b = '0;
		case (state_q)
			ST_ENV: begin
				mul_go   = 1'b1;
				mul_go_a = MUL_W'(d_c);
				mul_go_b = MUL_W'(coeff_c);
			end
			ST_LOG_SQ: begin
				mul_go   = 1'b1;
				mul_go_a = MUL_W'(n_q);
				mul_go_b = MUL_W'(n_q);
			end
			ST_SLOPE: begin
				mul_go   = 1'b1;
				mul_go_a = diff_q;
				mul_go_b = MUL_W'(slope_q);
			end
			ST_EXP1: begin
				mul_go   = 1'b1;
				mul_go_a = MUL_W'(EXP_C2);
				mul_go_b = MUL_W'(x_q);
			end
			ST_EXP2: begin
				mul_go   = 1'b1;
				mul_go_a = MUL_W'(x_q);
				mul_go_b = MUL_W'(c_q);
			end
			ST_OUT: begin
				mul_go   = ch_act;
				mul_go_a = MUL_W'(mag16(s_ch));
				mul_go_b = MUL_W'(gain_q);
			end
			default: begin
				mul_go = 1'b0;
			end
		endcase
	end

	assign frame_stall  = (state_q != ST_IDLE);
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;
	assign out_load     = (state_q == ST_DONE) && (!result_valid_q || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q          <= RST_THRESHOLD;
			slope_q        <= RST_SLOPE;
			atk_q          <= RST_ATTACK;
			rel_q          <= RST_RELEASE;
			chan_q         <= RST_CHANNELS;
			env_q          <= FULL_SCALE;
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			mul_busy_q     <= 1'b0;
			mul_cnt_q      <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_THRESHOLD: thr_q   <= cfg_data;
					REG_SLOPE:     slope_q <= cfg_data;
					REG_ATTACK:    atk_q   <= cfg_data;
					REG_RELEASE:   rel_q   <= cfg_data;
					REG_CHANNELS:  chan_q  <= cfg_data[2:0];
					default: ;
				endcase
			end

			if (out_load) result_valid_q <= 1'b1;
			else if (result_valid_q && !result_stall) result_valid_q <= 1'b0;

			// Multiplier: the top digit of b goes in first, acc shifts up.
			if (mul_busy_q) begin
				mul_acc_q <= {mul_acc_q[2*MUL_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}}
					+ (2*MUL_W)'(mul_a_q) * (2*MUL_W)'(mul_b_q[MUL_W-1 -: MUL_DIGIT]);
				mul_b_q   <= {mul_b_q[MUL_W-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
				mul_cnt_q <= mul_cnt_q + 3'd1;
				if (mul_cnt_q == MUL_LAST) mul_busy_q <= 1'b0;
			end else if (mul_go) begin
				mul_a_q    <= mul_go_a;
				mul_b_q    <= mul_go_b;
				mul_acc_q  <= '0;
				mul_cnt_q  <= '0;
				mul_busy_q <= 1'b1;
			end

			case (state_q)
				ST_IDLE: begin
					if (frame_valid) begin
						frame_q <= frame;
						count_q <= count_in;
						peak_q  <= peak_in;
						state_q <= ST_ENV;
					end
				end
				ST_ENV: begin
					target_q <= target_c;
					dn_q     <= (env_q >= target_c);
					state_q  <= ST_ENV_W;
				end
				ST_ENV_W: begin
					if (!mul_busy_q) begin
						env_q <= env_new;
						ch_q  <= 2'd0;
						if (env_new > thr_eff) begin
							log_sel_q <= 1'b0;
							state_q   <= ST_LOG_NORM;
						end else begin
							gain_q  <= GAIN_ONE;
							state_q <= ST_OUT;
						end
					end
				end
				ST_LOG_NORM: begin
					msb_q   <= log_msb;
					n_q     <= 16'(log_x << (4'd15 - log_msb));
					frac_q  <= '0;
					iter_q  <= '0;
					state_q <= ST_LOG_SQ;
				end
				ST_LOG_SQ: begin
					state_q <= ST_LOG_W;
				end
				ST_LOG_W: begin
					if (!mul_busy_q) begin
						frac_q <= frac_nx;
						n_q    <= n_nx;
						iter_q <= iter_q + 4'd1;
						if (iter_q == 4'd15) begin
							if (!log_sel_q) begin
								log_e_q   <= logv;
								log_sel_q <= 1'b1;
								state_q   <= ST_LOG_NORM;
							end else begin
								diff_q  <= log_e_q - logv;
								state_q <= ST_SLOPE;
							end
						end else begin
							state_q <= ST_LOG_SQ;
						end
					end
				end
				ST_SLOPE: begin
					state_q <= ST_SLOPE_W;
				end
				ST_SLOPE_W: begin
					if (!mul_busy_q) begin
						k_q <= slope_l[19:16];
						if (slope_l[15:0] == 16'd0) begin
							gain_q  <= GAIN_ONE >> slope_l[19:16];
							state_q <= ST_OUT;
						end else begin
							x_q     <= 17'(18'd65536 - {2'b00, slope_l[15:0]});
							state_q <= ST_EXP1;
						end
					end
				end
				ST_EXP1: begin
					state_q <= ST_EXP1_W;
				end
				ST_EXP1_W: begin
					if (!mul_busy_q) begin
						c_q     <= EXP_C1 + {1'b0, mul_acc_q[30:16]};
						state_q <= ST_EXP2;
					end
				end
				ST_EXP2: begin
					state_q <= ST_EXP2_W;
				end
				ST_EXP2_W: begin
					if (!mul_busy_q) begin
						gain_q  <= g_c[15:0];
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (ch_act) begin
						state_q <= ST_OUT_W;
					end else begin
						res_q[ch_q] <= '0;
						ch_q        <= ch_q + 2'd1;
						state_q     <= (ch_q == 2'd3) ? ST_DONE : ST_OUT;
					end
				end
				ST_OUT_W: begin
					if (!mul_busy_q) begin
						res_q[ch_q] <= prod_s[30:15];
						ch_q        <= ch_q + 2'd1;
						state_q     <= (ch_q == 2'd3) ? ST_DONE : ST_OUT;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						result_q.out_a        <= res_q[0];
						result_q.out_b        <= res_q[1];
						result_q.out_c        <= res_q[2];
						result_q.out_d        <= res_q[3];
						result_q.applied_gain <= gain_q;
						state_q               <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.applied_gain <= GAIN_ONE)
		else $error("applied gain above unity");

	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_q <= FULL_SCALE)
		else $error("envelope above full scale");

	a_mul_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_busy_q |-> (state_q == ST_ENV_W || state_q == ST_LOG_W ||
			state_q == ST_SLOPE_W || state_q == ST_EXP1_W ||
			state_q == ST_EXP2_W || state_q == ST_OUT_W))
		else $error("multiplier busy outside a wait state");

	a_done_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && !result_valid_q) |=> result_valid_q)
		else $error("finished frame not presented");

endmodule

// ===== tb/peak_compressor_gain_tb.sv =====
// ----------------------------------------------------------------------------
// peak_compressor_gain_tb
// Self-checking bench for the peak compressor gain stage. Frames are driven
// from a queue, each accepted frame is run through a bit-exact envelope and
// gain predictor, and every result beat is compared field by field.
// ----------------------------------------------------------------------------
module peak_compressor_gain_tb;
	import pcg_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	logic    clk;
	logic    arst_n;
	logic    frame_valid;
	logic    frame_stall;
	frame_t  frame;
	logic    result_valid;
	logic    result_stall;
	result_t result;
	logic    cfg_valid;
	logic    cfg_ready;
	logic [2:0]  cfg_index;
	logic [15:0] cfg_data;

	peak_compressor_gain i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.frame       (frame),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// Predictor copy of the configuration and the envelope.
	logic [15:0] thr_q, slope_q, att_q, rel_q;
	logic [2:0]  chan_q;
	logic [16:0] env_q;

	frame_t  pending_frames[$];
	result_t expected_results[$];
	int      send_idle_pct;
	int      recv_idle_pct;
	int      hold_cycles;
	int      error_count;
	bit      stimulus_done;
	bit      frame_taken;

	function automatic logic [63:0] log2_q16(input logic [63:0] x);
		int unsigned msb;
		logic [63:0] n, frac;
		msb = 0;
		frac = 0;
		if (x == 0)
			x = 1;
		while (msb < 63 && (x >> (msb + 1)) != 0)
			msb++;
		if (msb >= 15)
			n = x >> (msb - 15);
		else
			n = x << (15 - msb);
		for (int i = 0; i < 16; i++) begin
			n = (n * n) >> 15;
			frac = frac << 1;
			if (n >= 64'd65536) begin
				frac[0] = 1'b1;
				n = n >> 1;
			end
		end
		return (64'(msb) << 16) | frac;
	endfunction

	function automatic logic [63:0] exp2_neg_q15(input logic [63:0] l);
		logic [63:0] k, f, x, p;
		k = l >> 16;
		f = l & 64'hFFFF;
		if (k > 40)
			return 0;
		if (f == 0)
			return 64'(GAIN_ONE) >> k;
		x = 64'd65536 - f;
		p = 64'd65536 + ((x * (64'(EXP_C1) + ((64'(EXP_C2) * x) >> 16))) >> 16);
		return p >> (k + 2);
	endfunction

	// Advances the envelope for one frame and returns the scaled frame.
	function automatic result_t compress_frame(input frame_t f);
		logic signed [15:0] s[4];
		logic [63:0] count, thr, peak, target, coeff, d, step, gain, m, diff;
		logic signed [63:0] prod;
		logic [15:0] r[4];
		result_t res;
		s[0] = f.sample_a;
		s[1] = f.sample_b;
		s[2] = f.sample_c;
		s[3] = f.sample_d;
		count = chan_q;
		if (count < 1)
			count = 1;
		if (count > IO_CHANNELS)
			count = IO_CHANNELS;
		thr = (thr_q == 0) ? 64'd1 : 64'(thr_q);
		peak = 0;
		for (int i = 0; i < 4; i++) begin
			if (i < count) begin
				m = (s[i] < 0) ? 64'(-64'(s[i])) : 64'(s[i]);
				if (m > peak)
					peak = m;
			end
		end
		target = (peak > thr) ? peak : 64'(env_q);
		coeff = (peak > env_q) ? 64'(att_q) : 64'(rel_q);
		if (env_q >= target) begin
			d = env_q - target;
			step = (d * coeff) >> 16;
			env_q = 17'(target + step);
		end else begin
			d = target - env_q;
			step = (d * coeff) >> 16;
			env_q = 17'(target - step);
		end
		if (env_q > thr) begin
			diff = log2_q16(64'(env_q)) - log2_q16(thr);
			gain = exp2_neg_q15((diff * 64'(slope_q)) >> 16);
			if (gain > GAIN_ONE)
				gain = GAIN_ONE;
		end else begin
			gain = GAIN_ONE;
		end
		for (int i = 0; i < 4; i++) begin
			prod = 64'(s[i]) * $signed(gain);
			r[i] = (i < count) ? 16'(prod >>> 15) : 16'd0;
		end
		res.out_a = r[0];
		res.out_b = r[1];
		res.out_c = r[2];
		res.out_d = r[3];
		res.applied_gain = gain[15:0];
		return res;
	endfunction

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 255)) ^ {16{$urandom_range(0, 1) == 1}};
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic frame_t rand_frame();
		frame_t f;
		f.sample_a = rand_sample();
		f.sample_b = rand_sample();
		f.sample_c = rand_sample();
		f.sample_d = rand_sample();
		return f;
	endfunction

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("Verification failed");
		$finish;
	end

	// Frame driver: a beat is replaced only after it has been accepted.
	always @(negedge clk) begin
		if (!arst_n) begin
			frame_valid <= 1'b0;
		end else if (!frame_valid || frame_taken) begin
			if (pending_frames.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				frame_valid <= 1'b1;
				frame <= pending_frames.pop_front();
			end else begin
				frame_valid <= 1'b0;
			end
		end
	end

	// Result side: random stall plus a long hold-off when requested.
	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Monitor: predict on accepted frames, check accepted result beats.
	always @(posedge clk) begin
		result_t exp_r;
		frame_taken <= arst_n && frame_valid && !frame_stall;
		if (arst_n && frame_valid && !frame_stall)
			expected_results.push_back(compress_frame(frame));
		if (arst_n && result_valid && !result_stall) begin
			if (expected_results.size() == 0) begin
				$error("unexpected result beat");
				error_count++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.out_a !== exp_r.out_a) begin
					$error("out_a expected %0d actual %0d", exp_r.out_a, result.out_a);
					error_count++;
				end
				if (result.out_b !== exp_r.out_b) begin
					$error("out_b expected %0d actual %0d", exp_r.out_b, result.out_b);
					error_count++;
				end
				if (result.out_c !== exp_r.out_c) begin
					$error("out_c expected %0d actual %0d", exp_r.out_c, result.out_c);
					error_count++;
				end
				if (result.out_d !== exp_r.out_d) begin
					$error("out_d expected %0d actual %0d", exp_r.out_d, result.out_d);
					error_count++;
				end
				if (result.applied_gain !== exp_r.applied_gain) begin
					$error("applied_gain expected %0d actual %0d",
						exp_r.applied_gain, result.applied_gain);
					error_count++;
				end
			end
		end
	end

	task automatic wait_drained();
		while (pending_frames.size() != 0 || frame_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_THRESHOLD: thr_q = val;
			REG_SLOPE:     slope_q = val;
			REG_ATTACK:    att_q = val;
			REG_RELEASE:   rel_q = val;
			REG_CHANNELS:  chan_q = val[2:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic write_all(input logic [15:0] t, input logic [15:0] sl,
			input logic [15:0] a, input logic [15:0] r, input logic [2:0] c);
		write_reg(REG_THRESHOLD, t);
		write_reg(REG_SLOPE, sl);
		write_reg(REG_ATTACK, a);
		write_reg(REG_RELEASE, r);
		write_reg(REG_CHANNELS, 16'(c));
	endtask

	task automatic run_random(input int n);
		for (int i = 0; i < n; i++)
			pending_frames.push_back(rand_frame());
		wait_drained();
	endtask

	initial begin
		frame_t f;
		arst_n = 1'b0;
		frame_valid = 1'b0;
		frame = '0;
		result_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		hold_cycles = 0;
		error_count = 0;
		send_idle_pct = 8;
		recv_idle_pct = 51;
		thr_q = RST_THRESHOLD;
		slope_q = RST_SLOPE;
		att_q = RST_ATTACK;
		rel_q = RST_RELEASE;
		chan_q = RST_CHANNELS;
		env_q = 17'(FULL_SCALE);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed frames at reset settings: extremes, silence, inactive channels.
		f = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF};
		pending_frames.push_back(f);
		f = '{16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF};
		pending_frames.push_back(f);
		for (int i = 0; i < 4; i++)
			pending_frames.push_back('0);
		f = '{16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
		pending_frames.push_back(f);
		wait_drained();

		// Zero threshold, all channels, instant attack and release.
		write_all(16'd0, 16'd65535, 16'd0, 16'd0, 3'd4);
		pending_frames.push_back('{16'h8000, 16'h0000, 16'h0000, 16'h0000});
		pending_frames.push_back('{16'h0000, 16'h0000, 16'h0000, 16'h7FFF});
		pending_frames.push_back('{16'h0001, 16'hFFFF, 16'h0002, 16'hFFFE});
		pending_frames.push_back('0);
		wait_drained();
		// Channel count zero and above range; unknown register indexes.
		write_all(16'd32768, 16'd0, 16'd65535, 16'd65535, 3'd0);
		write_reg(3'd5, 16'hFFFF);
		write_reg(3'd7, 16'h0000);
		pending_frames.push_back('{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF});
		pending_frames.push_back('{16'h1234, 16'h8000, 16'h7FFF, 16'h8000});
		wait_drained();
		write_all(16'd1, 16'd40000, 16'd30000, 16'd60000, 3'd7);
		pending_frames.push_back('{16'h8000, 16'h7FFF, 16'h0100, 16'hFF00});
		pending_frames.push_back('{16'h0003, 16'h8001, 16'h7FFE, 16'h0000});
		pending_frames.push_back('0);
		wait_drained();

		// Random phases through several settings and idling patterns.
		for (int ph = 0; ph < 9; ph++) begin
			if (ph == 3) begin
				send_idle_pct = 51;
				recv_idle_pct = 8;
			end else if (ph == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_all(16'($urandom_range(1, 32768)), 16'($urandom),
				16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
				3'($urandom_range(1, 4)));
			if (ph == 4)
				hold_cycles = 3000;
			run_random(185);
		end
		stimulus_done = 1'b1;

		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
